// ===== hw/rtl/ptne_pkg.sv =====
// Shared types and constants for the point table with nearest and extreme queries.
`default_nettype none

package ptne_pkg;

	// Fixed field widths
	localparam int W_OP     = 2;
	localparam int W_INDEX  = 8;
	localparam int W_COORD  = 16;
	localparam int W_STATUS = 2;

	// Table defaults
	localparam int MAX_ENTRIES_DEF = 256;

	// Saturation top for an empty table, side 1
	localparam int COORD_BITS = 16;

	// Arithmetic widths of the distance path
	localparam int W_DIFF  = W_COORD + 1;
	localparam int W_SQ    = 2 * W_DIFF - 1;
	localparam int W_DIST  = W_SQ + 1;

	// Stored entry: {active, x, y}
	localparam int W_ENTRY = 2 * W_COORD + 1;

	// Running extreme must hold both a stored x and the saturation top
	localparam int RUN_W = (COORD_BITS > W_COORD) ? COORD_BITS : W_COORD;
	localparam logic signed [RUN_W-1:0] FRONT_TOP = RUN_W'((1 << (COORD_BITS - 1)) - 1);

	typedef enum logic [W_OP-1:0] {
		OP_REGISTER = 2'd0,
		OP_UPDATE   = 2'd1,
		OP_EXTREME  = 2'd2,
		OP_NEAREST  = 2'd3
	} op_t;

	typedef enum logic [W_STATUS-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ptne_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module ptne_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/point_table_nearest_and_extreme.sv =====
// Top level: point table with append/rewrite, extreme-x and nearest-entry queries.
//
// Input channel (in_valid / in_stall) takes one request per item: register,
// update, extreme query or nearest query. Output channel (out_valid /
// out_stall) returns exactly one result per request, in order.
// Register and update write the entry table in the accept cycle. A query
// streams the table through the RAM read port, one entry per cycle, through
// a two-stage distance pipeline; its result is loaded into the output
// register after the last entry has left the pipeline. An empty-table query
// skips the scan.
// One request is in flight at a time; in_stall is high until its result has
// moved into the output register, which holds it while out_stall is high.
// The next request can be accepted while that result still waits.
// Reset clears the entry count, the side register and both valids; table
// contents are left as they are and only written entries are ever read.
// cfg_wr_en writes the side register; write it only while no request is open.
`default_nettype none

module point_table_nearest_and_extreme #(
	parameter int MAX_ENTRIES = ptne_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic                                cfg_wr_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic        [ptne_pkg::W_OP-1:0]    operation,
	input  wire logic        [ptne_pkg::W_INDEX-1:0] entry_index,
	input  wire logic signed [ptne_pkg::W_COORD-1:0] entry_x,
	input  wire logic signed [ptne_pkg::W_COORD-1:0] entry_y,
	input  wire logic                                entry_active,
	input  wire logic signed [ptne_pkg::W_COORD-1:0] query_x,
	input  wire logic signed [ptne_pkg::W_COORD-1:0] query_y,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     found,
	output logic             [ptne_pkg::W_INDEX-1:0] result_index,
	output logic signed      [ptne_pkg::W_COORD-1:0] coordinate,
	output logic            [ptne_pkg::W_STATUS-1:0] status
);

	import ptne_pkg::*;

	localparam int ADDR_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > W_INDEX) ? CNT_W : W_INDEX;

	state_t st_q;
	logic   side_q;
	logic [CNT_W-1:0] count_q;
	logic   out_valid_q;

	// Request context
	op_t    op_q;
	logic signed [W_COORD-1:0] qx_q, qy_q;
	logic   found_q;
	logic [W_INDEX-1:0] ridx_q;
	status_t stat_q;
	logic signed [RUN_W-1:0] run_q;
	logic [W_DIST-1:0] best_q;

	// Scan pipeline
	logic   issuing_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic   v_s1, last_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic   v_s2, last_s2, act_s2;
	logic [ADDR_W-1:0] idx_s2;
	logic signed [W_COORD-1:0] x_s2;
	logic [W_SQ-1:0] sqx_s2, sqy_s2;

	// Output register
	logic   found_q2;
	logic [W_INDEX-1:0] out_idx_q;
	logic signed [W_COORD-1:0] out_coord_q;
	logic [W_STATUS-1:0] out_stat_q;

	logic   acc_in, full, idx_ok, scan_last, load_out;
	logic   wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [W_ENTRY-1:0] wr_data, rd_data;
	logic signed [W_COORD-1:0] rd_x, rd_y;
	logic signed [W_DIFF-1:0] dx, dy;
	logic [W_DIFF-1:0] ax, ay;
	logic [W_SQ-1:0] sqx, sqy;
	logic [W_DIST-1:0] dist_sum;
	logic signed [RUN_W-1:0] x_ext;

	assign acc_in    = in_valid && !in_stall;
	assign in_stall  = (st_q != S_IDLE);
	assign full      = (count_q == CNT_W'(MAX_ENTRIES));
	assign idx_ok    = (CMP_W'(entry_index) < CMP_W'(count_q));
	assign scan_last = ((CNT_W'(rd_ptr_q) + CNT_W'(1)) == count_q);
	assign load_out  = (st_q == S_FIN) && (!out_valid_q || !out_stall);

	assign wr_en   = acc_in && (((operation == OP_REGISTER) && !full) ||
	                            ((operation == OP_UPDATE) && idx_ok));
	assign wr_addr = (operation == OP_REGISTER) ? count_q[ADDR_W-1:0] : ADDR_W'(entry_index);
	assign wr_data = {entry_active, entry_x, entry_y};

	ptne_ram #(
		.WIDTH(W_ENTRY),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_ptr_q),
		.rd_data(rd_data)
	);

	// Stage 1: distance squares from the RAM output
	assign rd_x = rd_data[2*W_COORD-1:W_COORD];
	assign rd_y = rd_data[W_COORD-1:0];
	assign dx   = W_DIFF'(rd_x) - W_DIFF'(qx_q);
	assign dy   = W_DIFF'(rd_y) - W_DIFF'(qy_q);
	assign ax   = dx[W_DIFF-1] ? W_DIFF'(-dx) : W_DIFF'(dx);
	assign ay   = dy[W_DIFF-1] ? W_DIFF'(-dy) : W_DIFF'(dy);
	assign sqx  = W_SQ'(ax) * W_SQ'(ax);
	assign sqy  = W_SQ'(ay) * W_SQ'(ay);

	// Stage 2: accumulate
	assign dist_sum = W_DIST'(sqx_s2) + W_DIST'(sqy_s2);
	assign x_ext    = RUN_W'(x_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			side_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			issuing_q   <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				side_q <= cfg_wr_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			v_s1 <= issuing_q;
			v_s2 <= v_s1;
			unique case (st_q)
				S_IDLE: begin
					if (acc_in) begin
						if ((operation == OP_REGISTER) && !full) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (((operation == OP_EXTREME) || (operation == OP_NEAREST)) &&
						    (count_q != '0)) begin
							st_q      <= S_SCAN;
							issuing_q <= 1'b1;
						end else begin
							st_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					if (issuing_q && scan_last) begin
						issuing_q <= 1'b0;
					end
					if (v_s2 && last_s2) begin
						st_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (load_out) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			op_q     <= op_t'(operation);
			qx_q     <= query_x;
			qy_q     <= query_y;
			rd_ptr_q <= '0;
			found_q  <= 1'b0;
			run_q    <= ((operation == OP_EXTREME) && side_q) ? FRONT_TOP : '0;
			case (operation)
				OP_REGISTER: begin
					ridx_q <= full ? '0 : W_INDEX'(count_q);
					stat_q <= full ? ST_FULL : ST_OK;
				end
				OP_UPDATE: begin
					ridx_q <= idx_ok ? entry_index : '0;
					stat_q <= idx_ok ? ST_OK : ST_BAD_INDEX;
				end
				default: begin
					ridx_q <= '0;
					stat_q <= ST_OK;
				end
			endcase
		end
		if (issuing_q) begin
			rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
		end

		idx_s1  <= rd_ptr_q;
		last_s1 <= scan_last;

		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		act_s2  <= rd_data[W_ENTRY-1];
		x_s2    <= rd_x;
		sqx_s2  <= sqx;
		sqy_s2  <= sqy;

		if (v_s2) begin
			if (op_q == OP_EXTREME) begin
				if (side_q ? (x_ext < run_q) : (x_ext > run_q)) begin
					run_q <= x_ext;
				end
			end else if (act_s2 && (!found_q || (dist_sum < best_q))) begin
				// strict compare keeps the lowest index on a tie
				best_q  <= dist_sum;
				ridx_q  <= W_INDEX'(idx_s2);
				found_q <= 1'b1;
			end
		end

		if (load_out) begin
			found_q2    <= found_q;
			out_idx_q   <= ridx_q;
			out_coord_q <= (op_q == OP_EXTREME) ? run_q[W_COORD-1:0] : '0;
			out_stat_q  <= stat_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q2;
	assign result_index = out_idx_q;
	assign coordinate   = out_coord_q;
	assign status       = out_stat_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above table size");

	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(issuing_q || v_s1 || v_s2) |-> (st_q == S_SCAN))
		else $error("scan pipeline active outside scan");

	a_reg_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && (operation == OP_REGISTER) && !full) |=>
		(count_q == $past(count_q) + CNT_W'(1)))
		else $error("register request did not advance entry count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |=> (st_q != S_IDLE))
		else $error("accepted request left no work open");
`endif

endmodule

`default_nettype wire

// ===== test/point_table_checker.sv =====
`timescale 1ns / 100ps
// Checker for the point table: tracks the table, predicts each result and compares it.
module point_table_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic                                cfg_wr_data,
	input  wire logic                                in_valid,
	input  wire logic                                in_stall,
	input  wire logic        [ptne_pkg::W_OP-1:0]    operation,
	input  wire logic        [ptne_pkg::W_INDEX-1:0] entry_index,
	input  wire logic signed [ptne_pkg::W_COORD-1:0] entry_x,
	input  wire logic signed [ptne_pkg::W_COORD-1:0] entry_y,
	input  wire logic                                entry_active,
	input  wire logic signed [ptne_pkg::W_COORD-1:0] query_x,
	input  wire logic signed [ptne_pkg::W_COORD-1:0] query_y,
	input  wire logic                                out_valid,
	input  wire logic                                out_stall,
	input  wire logic                                found,
	input  wire logic        [ptne_pkg::W_INDEX-1:0] result_index,
	input  wire logic signed [ptne_pkg::W_COORD-1:0] coordinate,
	input  wire logic       [ptne_pkg::W_STATUS-1:0] status,
	output int                                       mismatches,
	output int                                       outstanding
);
	import ptne_pkg::*;

	localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;

	typedef struct packed {
		logic                      found;
		logic [W_INDEX-1:0]        index;
		logic signed [W_COORD-1:0] coord;
		status_t                   status;
	} point_result_t;

	logic signed [W_COORD-1:0] x_tab [TABLE_DEPTH];
	logic signed [W_COORD-1:0] y_tab [TABLE_DEPTH];
	logic                      active_tab [TABLE_DEPTH];
	int                        fill = 0;
	logic                      side = 1'b0;
	int                        error_total = 0;
	point_result_t             expected_results [$];

	function automatic point_result_t predict_result(
		input op_t                       op,
		input logic [W_INDEX-1:0]        idx,
		input logic signed [W_COORD-1:0] ex,
		input logic signed [W_COORD-1:0] ey,
		input logic                      ea,
		input logic signed [W_COORD-1:0] qx,
		input logic signed [W_COORD-1:0] qy
	);
		point_result_t r;
		int front;
		longint dx;
		longint dy;
		longint sq_dist;
		longint best;
		r = '0;
		r.status = ST_OK;
		best = 0;
		case (op)
			OP_REGISTER: begin
				if (fill < TABLE_DEPTH) begin
					x_tab[fill] = ex;
					y_tab[fill] = ey;
					active_tab[fill] = ea;
					r.index = W_INDEX'(fill);
					fill++;
				end else begin
					r.status = ST_FULL;
				end
			end
			OP_UPDATE: begin
				if (int'(idx) < fill) begin
					x_tab[idx] = ex;
					y_tab[idx] = ey;
					active_tab[idx] = ea;
					r.index = idx;
				end else begin
					r.status = ST_BAD_INDEX;
				end
			end
			OP_EXTREME: begin
				// side 0: largest x floored at 0; side 1: smallest x from the top coordinate
				front = side ? (1 << (COORD_BITS - 1)) - 1 : 0;
				for (int i = 0; i < fill; i++)
					if (side ? (x_tab[i] < front) : (x_tab[i] > front))
						front = x_tab[i];
				r.coord = W_COORD'(front);
			end
			default: begin
				for (int i = 0; i < fill; i++) begin
					if (active_tab[i]) begin
						dx = longint'(x_tab[i]) - longint'(qx);
						dy = longint'(y_tab[i]) - longint'(qy);
						sq_dist = dx * dx + dy * dy;
						// strict less-than keeps the lowest index on a tie
						if (!r.found || sq_dist < best) begin
							best = sq_dist;
							r.index = W_INDEX'(i);
							r.found = 1'b1;
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_field(input string field_name, input int want_v, input int got_v);
		$display("%0t: %s expected %0d got %0d", $time, field_name, want_v, got_v);
		error_total++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		point_result_t want;
		if (!arst_n) begin
			fill = 0;
			side = 1'b0;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with no request waiting: found %0b index %0d coordinate %0d status %0d",
						$time, found, result_index, coordinate, status);
					error_total++;
				end else begin
					want = expected_results.pop_front();
					if (found !== want.found)
						report_field("found", int'(want.found), int'(found));
					if (result_index !== want.index)
						report_field("result_index", int'(want.index), int'(result_index));
					if (coordinate !== want.coord)
						report_field("coordinate", int'(want.coord), int'(coordinate));
					if (status !== want.status)
						report_field("status", int'(want.status), int'(status));
				end
			end
			if (cfg_wr_en)
				side = cfg_wr_data;
			if (in_valid && !in_stall)
				expected_results = {expected_results, predict_result(op_t'(operation),
					entry_index, entry_x, entry_y, entry_active, query_x, query_y)};
			outstanding <= expected_results.size();
		end
		mismatches <= error_total;
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top: drives point table requests and side settings and gives the verdict.
module testbench;
	import ptne_pkg::*;

	localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
	localparam int CYCLE_LIMIT = 1_000_000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_wr_en = 1'b0;
	logic                      cfg_wr_data = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [W_OP-1:0]           operation = '0;
	logic [W_INDEX-1:0]        entry_index = '0;
	logic signed [W_COORD-1:0] entry_x = '0;
	logic signed [W_COORD-1:0] entry_y = '0;
	logic                      entry_active = 1'b0;
	logic signed [W_COORD-1:0] query_x = '0;
	logic signed [W_COORD-1:0] query_y = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      found;
	logic [W_INDEX-1:0]        result_index;
	logic signed [W_COORD-1:0] coordinate;
	logic [W_STATUS-1:0]       status;

	int mismatches;
	int outstanding;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int fill = 0;	// entries the table holds, for stimulus choices only

	always #1 clk = ~clk;

	point_table_nearest_and_extreme dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.entry_index(entry_index), .entry_x(entry_x), .entry_y(entry_y),
		.entry_active(entry_active), .query_x(query_x), .query_y(query_y),
		.out_valid(out_valid), .out_stall(out_stall), .found(found),
		.result_index(result_index), .coordinate(coordinate), .status(status)
	);

	point_table_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.entry_index(entry_index), .entry_x(entry_x), .entry_y(entry_y),
		.entry_active(entry_active), .query_x(query_x), .query_y(query_y),
		.out_valid(out_valid), .out_stall(out_stall), .found(found),
		.result_index(result_index), .coordinate(coordinate), .status(status),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always @(posedge clk) begin
		out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("point_table_nearest_and_extreme: mismatch");
			$finish;
		end
	end

	task automatic send_request(
		input op_t                       op,
		input logic [W_INDEX-1:0]        idx,
		input logic signed [W_COORD-1:0] ex,
		input logic signed [W_COORD-1:0] ey,
		input logic                      ea,
		input logic signed [W_COORD-1:0] qx,
		input logic signed [W_COORD-1:0] qy
	);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		entry_index <= idx;
		entry_x <= ex;
		entry_y <= ey;
		entry_active <= ea;
		query_x <= qx;
		query_y <= qy;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (op == OP_REGISTER && fill < TABLE_DEPTH)
			fill++;
	endtask

	// side register is only written with no request open
	task automatic set_side(input logic value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mix of full range, a tight cluster near the origin (for ties) and the extremes
	function automatic logic signed [W_COORD-1:0] rand_coord();
		int pick;
		pick = $urandom_range(9);
		if (pick < 3)
			return W_COORD'(int'($urandom_range(16)) - 8);
		else if (pick == 3)
			return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
		else
			return W_COORD'($urandom);
	endfunction

	task automatic random_request();
		int pick;
		op_t op;
		logic [W_INDEX-1:0] idx;
		pick = $urandom_range(99);
		if (fill < TABLE_DEPTH) begin
			if (pick < 40)
				op = OP_REGISTER;
			else if (pick < 62)
				op = OP_UPDATE;
			else if (pick < 75)
				op = OP_EXTREME;
			else
				op = OP_NEAREST;
		end else begin
			if (pick < 10)
				op = OP_REGISTER;
			else if (pick < 45)
				op = OP_UPDATE;
			else if (pick < 65)
				op = OP_EXTREME;
			else
				op = OP_NEAREST;
		end
		if (fill > 0 && $urandom_range(99) < 80)
			idx = W_INDEX'($urandom_range(fill - 1));
		else
			idx = W_INDEX'($urandom_range(255));
		send_request(op, idx, rand_coord(), rand_coord(), $urandom_range(3) != 0,
			rand_coord(), rand_coord());
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table with side 1, then side 0
		set_side(1'b1);
		send_request(OP_EXTREME, 8'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0);
		send_request(OP_NEAREST, 8'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0);
		send_request(OP_UPDATE, 8'd0, 16'sd1, 16'sd1, 1'b1, 16'sd0, 16'sd0);
		set_side(1'b0);
		send_request(OP_EXTREME, 8'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0);
		// one inactive, all-negative entry
		send_request(OP_REGISTER, 8'd0, 16'sh8000, 16'sh8000, 1'b0, 16'sd0, 16'sd0);
		send_request(OP_NEAREST, 8'd0, 16'sd0, 16'sd0, 1'b0, 16'sh8000, 16'sh8000);
		send_request(OP_EXTREME, 8'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0);
		send_request(OP_REGISTER, 8'd0, 16'sh7fff, 16'sh7fff, 1'b0, 16'sd0, 16'sd0);
		send_request(OP_EXTREME, 8'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0);
		send_request(OP_UPDATE, 8'd0, 16'sh8000, 16'sh8000, 1'b1, 16'sd0, 16'sd0);
		send_request(OP_NEAREST, 8'd0, 16'sd0, 16'sd0, 1'b0, 16'sh7fff, 16'sh7fff);
		// equidistant pair: the lower index wins
		send_request(OP_REGISTER, 8'd0, 16'sd10, 16'sd0, 1'b1, 16'sd0, 16'sd0);
		send_request(OP_REGISTER, 8'd0, -16'sd10, 16'sd0, 1'b1, 16'sd0, 16'sd0);
		send_request(OP_NEAREST, 8'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0);
		send_request(OP_UPDATE, 8'd3, 16'sd5, -16'sd5, 1'b1, 16'sd0, 16'sd0);
		send_request(OP_NEAREST, 8'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0);
		send_request(OP_UPDATE, 8'd4, 16'sd7, 16'sd7, 1'b1, 16'sd0, 16'sd0);
		send_request(OP_UPDATE, 8'd255, 16'sd7, 16'sd7, 1'b1, 16'sd0, 16'sd0);
		send_request(OP_NEAREST, 8'd0, 16'sd0, 16'sd0, 1'b0, 16'sh8000, 16'sh7fff);
		set_side(1'b1);
		send_request(OP_EXTREME, 8'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0);
		send_request(OP_NEAREST, 8'd0, 16'sd0, 16'sd0, 1'b0, 16'sh7fff, 16'sh8000);

		for (int phase = 0; phase < 5; phase++) begin
			set_side(phase[0]);
			case (phase % 4)
				0: begin
					idle_pct <= 0;
					stall_pct <= 0;
				end
				1: begin
					idle_pct <= 69;
					stall_pct <= 0;
				end
				2: begin
					idle_pct <= 0;
					stall_pct <= 69;
				end
				default: begin
					idle_pct <= 21;
					stall_pct <= 21;
				end
			endcase
			repeat (150) random_request();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("point_table_nearest_and_extreme: match");
		else
			$display("point_table_nearest_and_extreme: mismatch");
		$finish;
	end

endmodule

// ===== point_table_nearest_and_extreme.f =====
hw/rtl/ptne_pkg.sv
hw/rtl/ptne_ram.sv
hw/rtl/point_table_nearest_and_extreme.sv
test/point_table_checker.sv
test/testbench.sv
